>>> sv/lmc_pkg.sv
// ----------------------------------------------------------------------------
// lmc_pkg
// Shared constants, direction sign tables and types for the D3Q19 moment unit.
// ----------------------------------------------------------------------------
package lmc_pkg;

	localparam int NODE_INDEX_BITS_DEF = 20;
	localparam int DATA_BITS_DEF       = 32;
	localparam int FRAC_BITS_DEF       = 28;

	// accumulators grow by five bits over the data width, capped
	localparam int ACC_GROWTH = 5;
	localparam int ACC_MAX    = 62;

	localparam logic [7:0] SKIP_MASK = 8'd28;
	localparam logic [4:0] NUM_DIRS  = 5'd19;

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		SGN_ZERO,
		SGN_POS,
		SGN_NEG
	} sign_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_DONE
	} back_state_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} queue_status_t;

	function automatic int acc_bits(input int data_bits);
		return (data_bits + ACC_GROWTH > ACC_MAX) ? ACC_MAX : data_bits + ACC_GROWTH;
	endfunction

	function automatic sign_t sign_x(input logic [4:0] dir);
		case (dir)
			5'd1, 5'd7, 5'd9, 5'd15, 5'd17:   return SGN_POS;
			5'd2, 5'd8, 5'd10, 5'd16, 5'd18:  return SGN_NEG;
			default:                          return SGN_ZERO;
		endcase
	endfunction

	function automatic sign_t sign_y(input logic [4:0] dir);
		case (dir)
			5'd3, 5'd7, 5'd8, 5'd11, 5'd13:   return SGN_POS;
			5'd4, 5'd9, 5'd10, 5'd12, 5'd14:  return SGN_NEG;
			default:                          return SGN_ZERO;
		endcase
	endfunction

	function automatic sign_t sign_z(input logic [4:0] dir);
		case (dir)
			5'd5, 5'd11, 5'd12, 5'd15, 5'd16: return SGN_POS;
			5'd6, 5'd13, 5'd14, 5'd17, 5'd18: return SGN_NEG;
			default:                          return SGN_ZERO;
		endcase
	endfunction

endpackage

>>> sv/lmc_front.sv
// ----------------------------------------------------------------------------
// lmc_front
// Accepts direction words, accumulates density, momenta and phase sum, and
// pushes one node record into the queue on the last word of a node.
// ----------------------------------------------------------------------------
module lmc_front #(
	parameter int NODE_INDEX_BITS = lmc_pkg::NODE_INDEX_BITS_DEF,
	parameter int DATA_BITS       = lmc_pkg::DATA_BITS_DEF,
	parameter int ACC_BITS        = lmc_pkg::acc_bits(lmc_pkg::DATA_BITS_DEF)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic        [NODE_INDEX_BITS-1:0] node_index,
	input  logic        [4:0]                 direction,
	input  logic signed [DATA_BITS-1:0]       f_value,
	input  logic signed [DATA_BITS-1:0]       g_value,
	input  logic        [7:0]                 node_mask,
	input  logic                              last_direction,
	input  logic                              queue_full,
	output logic                              push,
	output logic        [NODE_INDEX_BITS-1:0] rec_node,
	output logic                              rec_ok,
	output logic        [ACC_BITS-1:0]        rec_density,
	output logic        [ACC_BITS-1:0]        rec_mx,
	output logic        [ACC_BITS-1:0]        rec_my,
	output logic        [ACC_BITS-1:0]        rec_mz,
	output logic        [ACC_BITS-1:0]        rec_phase
);

	logic                accept;
	logic                dir_ok;
	logic [ACC_BITS-1:0] f_ext;
	logic [ACC_BITS-1:0] g_ext;
	logic [ACC_BITS-1:0] den_q, mx_q, my_q, mz_q, phase_q;
	logic [ACC_BITS-1:0] den_n, mx_n, my_n, mz_n, phase_n;

	assign in_stall = queue_full;
	assign accept   = in_valid && !in_stall;
	assign dir_ok   = direction < lmc_pkg::NUM_DIRS;
	assign f_ext    = ACC_BITS'(f_value);
	assign g_ext    = ACC_BITS'(g_value);

	always_comb begin
		den_n   = dir_ok ? den_q + f_ext : den_q;
		phase_n = dir_ok ? phase_q + g_ext : phase_q;
		case (lmc_pkg::sign_x(direction))
			lmc_pkg::SGN_POS: mx_n = mx_q + f_ext;
			lmc_pkg::SGN_NEG: mx_n = mx_q - f_ext;
			default:          mx_n = mx_q;
		endcase
		case (lmc_pkg::sign_y(direction))
			lmc_pkg::SGN_POS: my_n = my_q + f_ext;
			lmc_pkg::SGN_NEG: my_n = my_q - f_ext;
			default:          my_n = my_q;
		endcase
		case (lmc_pkg::sign_z(direction))
			lmc_pkg::SGN_POS: mz_n = mz_q + f_ext;
			lmc_pkg::SGN_NEG: mz_n = mz_q - f_ext;
			default:          mz_n = mz_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			den_q   <= '0;
			mx_q    <= '0;
			my_q    <= '0;
			mz_q    <= '0;
			phase_q <= '0;
		end else if (accept) begin
			if (last_direction) begin
				den_q   <= '0;
				mx_q    <= '0;
				my_q    <= '0;
				mz_q    <= '0;
				phase_q <= '0;
			end else begin
				den_q   <= den_n;
				mx_q    <= mx_n;
				my_q    <= my_n;
				mz_q    <= mz_n;
				phase_q <= phase_n;
			end
		end
	end

	assign push        = accept && last_direction;
	assign rec_node    = node_index;
	assign rec_ok      = node_mask != lmc_pkg::SKIP_MASK;
	assign rec_density = den_n;
	assign rec_mx      = mx_n;
	assign rec_my      = my_n;
	assign rec_mz      = mz_n;
	assign rec_phase   = phase_n;

endmodule

>>> sv/lmc_queue.sv
// ----------------------------------------------------------------------------
// lmc_queue
// Short FIFO of node records between the accumulating front and the divider.
// ----------------------------------------------------------------------------
module lmc_queue #(
	parameter int WIDTH = 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [WIDTH-1:0]             push_data,
	input  logic                         pop,
	output logic [WIDTH-1:0]             pop_data,
	output lmc_pkg::queue_status_t       status
);

	localparam int PTR_BITS = (lmc_pkg::QUEUE_DEPTH > 1) ? $clog2(lmc_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(lmc_pkg::QUEUE_DEPTH + 1);

	logic [WIDTH-1:0]    mem_q [lmc_pkg::QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_push, do_pop;

	assign status.full      = count_q == CNT_BITS'(lmc_pkg::QUEUE_DEPTH);
	assign status.not_empty = count_q != '0;
	assign do_push          = push && !status.full;
	assign do_pop           = pop && status.not_empty;
	assign pop_data         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(lmc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(lmc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> sv/lmc_back.sv
// ----------------------------------------------------------------------------
// lmc_back
// Takes node records from the queue, divides the three momenta by density
// one quotient bit per cycle with saturation, and holds the result word.
// ----------------------------------------------------------------------------
module lmc_back #(
	parameter int NODE_INDEX_BITS = lmc_pkg::NODE_INDEX_BITS_DEF,
	parameter int DATA_BITS       = lmc_pkg::DATA_BITS_DEF,
	parameter int FRAC_BITS       = lmc_pkg::FRAC_BITS_DEF,
	parameter int ACC_BITS        = lmc_pkg::acc_bits(lmc_pkg::DATA_BITS_DEF)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lmc_pkg::queue_status_t            q_status,
	output logic                              pop,
	input  logic        [NODE_INDEX_BITS-1:0] rec_node,
	input  logic                              rec_ok,
	input  logic        [ACC_BITS-1:0]        rec_density,
	input  logic        [ACC_BITS-1:0]        rec_mx,
	input  logic        [ACC_BITS-1:0]        rec_my,
	input  logic        [ACC_BITS-1:0]        rec_mz,
	input  logic        [ACC_BITS-1:0]        rec_phase,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic        [NODE_INDEX_BITS-1:0] result_node,
	output logic                              moments_valid,
	output logic signed [ACC_BITS-1:0]        density,
	output logic signed [DATA_BITS-1:0]       velocity_x,
	output logic signed [DATA_BITS-1:0]       velocity_y,
	output logic signed [DATA_BITS-1:0]       velocity_z,
	output logic signed [ACC_BITS-1:0]        order_parameter,
	output logic                              divide_fault
);

	localparam int NUM_STEPS = ACC_BITS + FRAC_BITS;
	localparam int STEP_BITS = $clog2(NUM_STEPS);
	localparam logic [DATA_BITS-1:0] CAP     = {1'b1, {(DATA_BITS-1){1'b0}}};
	localparam logic [DATA_BITS-1:0] HALF    = {2'b01, {(DATA_BITS-2){1'b0}}};
	localparam logic [DATA_BITS-1:0] MAX_POS = {1'b0, {(DATA_BITS-1){1'b1}}};

	lmc_pkg::back_state_t state_q, state_n;

	logic                       load_out;
	logic                       div_run;
	logic                       zero_den;
	logic [STEP_BITS-1:0]       step_q;
	logic [NODE_INDEX_BITS-1:0] node_q;
	logic                       ok_q;
	logic                       fault_q;
	logic [ACC_BITS-1:0]        den_q;
	logic [ACC_BITS-1:0]        phase_q;
	logic [ACC_BITS-1:0]        dmag_q;
	logic [ACC_BITS-1:0]        num_in [3];
	logic [ACC_BITS-1:0]        n_q    [3];
	logic [ACC_BITS-1:0]        r_q    [3];
	logic [DATA_BITS-1:0]       q_q    [3];
	logic                       neg_q  [3];
	logic [ACC_BITS:0]          t_w    [3];
	logic [ACC_BITS-1:0]        r_n    [3];
	logic [DATA_BITS-1:0]       q_n    [3];
	logic [DATA_BITS-1:0]       qs_w   [3];
	logic                       qbit_w [3];
	logic [DATA_BITS-1:0]       vel_w  [3];

	assign zero_den  = rec_density == '0;
	assign num_in[0] = rec_mx;
	assign num_in[1] = rec_my;
	assign num_in[2] = rec_mz;

	function automatic logic [ACC_BITS-1:0] mag(input logic [ACC_BITS-1:0] v);
		return v[ACC_BITS-1] ? ACC_BITS'(~v + 1'b1) : v;
	endfunction

	always_comb begin
		state_n  = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		div_run  = 1'b0;
		case (state_q)
			lmc_pkg::BK_IDLE: begin
				if (q_status.not_empty) begin
					pop     = 1'b1;
					state_n = (rec_ok && !zero_den) ? lmc_pkg::BK_DIV : lmc_pkg::BK_DONE;
				end
			end
			lmc_pkg::BK_DIV: begin
				div_run = 1'b1;
				if (step_q == STEP_BITS'(NUM_STEPS - 1)) begin
					state_n = lmc_pkg::BK_DONE;
				end
			end
			lmc_pkg::BK_DONE: begin
				if (!out_valid || !out_stall) begin
					load_out = 1'b1;
					state_n  = lmc_pkg::BK_IDLE;
				end
			end
			default: state_n = lmc_pkg::BK_IDLE;
		endcase
	end

	// restoring division with the quotient clamped at CAP
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			t_w[i] = {r_q[i], n_q[i][ACC_BITS-1]};
			if (t_w[i] >= {1'b0, dmag_q}) begin
				r_n[i]    = ACC_BITS'(t_w[i] - {1'b0, dmag_q});
				qbit_w[i] = 1'b1;
			end else begin
				r_n[i]    = t_w[i][ACC_BITS-1:0];
				qbit_w[i] = 1'b0;
			end
			qs_w[i] = {q_q[i][DATA_BITS-2:0], qbit_w[i]};
			if (q_q[i] > HALF) begin
				q_n[i] = CAP;
			end else begin
				q_n[i] = (qs_w[i] > CAP) ? CAP : qs_w[i];
			end
			if (!ok_q || fault_q) begin
				vel_w[i] = '0;
			end else if (neg_q[i]) begin
				vel_w[i] = DATA_BITS'(~q_q[i] + 1'b1);
			end else begin
				vel_w[i] = q_q[i][DATA_BITS-1] ? MAX_POS : q_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lmc_pkg::BK_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_n;
			if (load_out) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			node_q  <= rec_node;
			ok_q    <= rec_ok;
			fault_q <= rec_ok && zero_den;
			den_q   <= rec_density;
			phase_q <= rec_phase;
			dmag_q  <= mag(rec_density);
			step_q  <= '0;
			for (int i = 0; i < 3; i++) begin
				n_q[i]   <= mag(num_in[i]);
				r_q[i]   <= '0;
				q_q[i]   <= '0;
				neg_q[i] <= num_in[i][ACC_BITS-1] ^ rec_density[ACC_BITS-1];
			end
		end else if (div_run) begin
			step_q <= step_q + 1'b1;
			for (int i = 0; i < 3; i++) begin
				n_q[i] <= {n_q[i][ACC_BITS-2:0], 1'b0};
				r_q[i] <= r_n[i];
				q_q[i] <= q_n[i];
			end
		end
		if (load_out) begin
			result_node     <= node_q;
			moments_valid   <= ok_q;
			density         <= ok_q ? den_q : '0;
			order_parameter <= ok_q ? phase_q : '0;
			divide_fault    <= fault_q;
			velocity_x      <= vel_w[0];
			velocity_y      <= vel_w[1];
			velocity_z      <= vel_w[2];
		end
	end

endmodule

>>> sv/lbm_d3q19_moment_compute.sv
// ----------------------------------------------------------------------------
// lbm_d3q19_moment_compute
// D3Q19 lattice Boltzmann moment unit: density, velocity and order parameter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one word per cycle unless stalled:
//   f and g values of one direction of a node, last_direction on the final
//   word. Words are summed as they arrive; the last word closes the node.
//   Output channel (out_valid / out_stall) carries one result word per node.
//   The three velocities are computed by three bit-serial dividers that run
//   together, one quotient bit per cycle over ACC_BITS + FRAC_BITS steps
//   (65 at the defaults). After the last word the record passes through the
//   queue, is popped in BK_IDLE, divided in BK_DIV and registered to the
//   output in BK_DONE; masked nodes and zero density skip the divide. The
//   divider takes a new record only once the last result word is loaded; a
//   two-entry record queue lets the front keep summing the next node meanwhile.
//   in_stall rises only when the queue is full. A stalled output word holds
//   while the next node is divided. Reset clears the sums, queue and valid.
// ----------------------------------------------------------------------------
module lbm_d3q19_moment_compute #(
	parameter int NODE_INDEX_BITS = lmc_pkg::NODE_INDEX_BITS_DEF,
	parameter int DATA_BITS       = lmc_pkg::DATA_BITS_DEF,
	parameter int FRAC_BITS       = lmc_pkg::FRAC_BITS_DEF,
	localparam int ACC_BITS       = lmc_pkg::acc_bits(DATA_BITS)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic        [NODE_INDEX_BITS-1:0] node_index,
	input  logic        [4:0]                 direction,
	input  logic signed [DATA_BITS-1:0]       f_value,
	input  logic signed [DATA_BITS-1:0]       g_value,
	input  logic        [7:0]                 node_mask,
	input  logic                              last_direction,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic        [NODE_INDEX_BITS-1:0] result_node,
	output logic                              moments_valid,
	output logic signed [ACC_BITS-1:0]        density,
	output logic signed [DATA_BITS-1:0]       velocity_x,
	output logic signed [DATA_BITS-1:0]       velocity_y,
	output logic signed [DATA_BITS-1:0]       velocity_z,
	output logic signed [ACC_BITS-1:0]        order_parameter,
	output logic                              divide_fault
);

	localparam int REC_BITS = NODE_INDEX_BITS + 1 + 5 * ACC_BITS;

	lmc_pkg::queue_status_t     q_status;
	logic                       push, pop;
	logic [REC_BITS-1:0]        push_data, pop_data;
	logic [NODE_INDEX_BITS-1:0] f_node, b_node;
	logic                       f_ok, b_ok;
	logic [ACC_BITS-1:0]        f_den, f_mx, f_my, f_mz, f_phase;
	logic [ACC_BITS-1:0]        b_den, b_mx, b_my, b_mz, b_phase;

	lmc_front #(
		.NODE_INDEX_BITS(NODE_INDEX_BITS),
		.DATA_BITS      (DATA_BITS),
		.ACC_BITS       (ACC_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.node_index    (node_index),
		.direction     (direction),
		.f_value       (f_value),
		.g_value       (g_value),
		.node_mask     (node_mask),
		.last_direction(last_direction),
		.queue_full    (q_status.full),
		.push          (push),
		.rec_node      (f_node),
		.rec_ok        (f_ok),
		.rec_density   (f_den),
		.rec_mx        (f_mx),
		.rec_my        (f_my),
		.rec_mz        (f_mz),
		.rec_phase     (f_phase)
	);

	assign push_data = {f_node, f_ok, f_den, f_mx, f_my, f_mz, f_phase};

	lmc_queue #(
		.WIDTH(REC_BITS)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.status   (q_status)
	);

	assign {b_node, b_ok, b_den, b_mx, b_my, b_mz, b_phase} = pop_data;

	lmc_back #(
		.NODE_INDEX_BITS(NODE_INDEX_BITS),
		.DATA_BITS      (DATA_BITS),
		.FRAC_BITS      (FRAC_BITS),
		.ACC_BITS       (ACC_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_status       (q_status),
		.pop            (pop),
		.rec_node       (b_node),
		.rec_ok         (b_ok),
		.rec_density    (b_den),
		.rec_mx         (b_mx),
		.rec_my         (b_my),
		.rec_mz         (b_mz),
		.rec_phase      (b_phase),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_node    (result_node),
		.moments_valid  (moments_valid),
		.density        (density),
		.velocity_x     (velocity_x),
		.velocity_y     (velocity_y),
		.velocity_z     (velocity_z),
		.order_parameter(order_parameter),
		.divide_fault   (divide_fault)
	);

endmodule

>>> sv/lmc_checker.sv
// ----------------------------------------------------------------------------
// lmc_checker
// Port-level checks on the result words of the moment unit, bound to the top.
// ----------------------------------------------------------------------------
module lmc_checker #(
	parameter int NODE_INDEX_BITS = lmc_pkg::NODE_INDEX_BITS_DEF,
	parameter int DATA_BITS       = lmc_pkg::DATA_BITS_DEF,
	parameter int ACC_BITS        = lmc_pkg::acc_bits(lmc_pkg::DATA_BITS_DEF)
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic        [NODE_INDEX_BITS-1:0] result_node,
	input logic                              moments_valid,
	input logic signed [ACC_BITS-1:0]        density,
	input logic signed [DATA_BITS-1:0]       velocity_x,
	input logic signed [DATA_BITS-1:0]       velocity_y,
	input logic signed [DATA_BITS-1:0]       velocity_z,
	input logic signed [ACC_BITS-1:0]        order_parameter,
	input logic                              divide_fault
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_node) && $stable(density)
			&& $stable(velocity_x) && $stable(velocity_y) && $stable(velocity_z))
		else $error("result word changed while stalled");

	a_masked_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !moments_valid |-> density == '0 && order_parameter == '0
			&& !divide_fault && velocity_x == '0 && velocity_y == '0 && velocity_z == '0)
		else $error("masked node carries moments");

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_fault |-> moments_valid && density == '0
			&& velocity_x == '0 && velocity_y == '0 && velocity_z == '0)
		else $error("divide fault with nonzero density or velocity");

	a_zero_faults: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && moments_valid && density == '0 |-> divide_fault)
		else $error("zero density without divide fault");

endmodule

bind lbm_d3q19_moment_compute lmc_checker #(
	.NODE_INDEX_BITS(NODE_INDEX_BITS),
	.DATA_BITS      (DATA_BITS),
	.ACC_BITS       (ACC_BITS)
) u_lmc_checker (.*);

>>> test/lbm_moment_checker.sv
// ----------------------------------------------------------------------------
// lbm_moment_checker
// Watches both channels of the D3Q19 moment unit. Every accepted direction
// word feeds a bit-accurate model of the density, momentum and phase sums.
// Each last word queues the moments that node should produce. Every accepted
// result word is compared field by field against the oldest queued node.
// ----------------------------------------------------------------------------
module lbm_moment_checker #(
	parameter int NODE_INDEX_BITS = lmc_pkg::NODE_INDEX_BITS_DEF,
	parameter int DATA_BITS       = lmc_pkg::DATA_BITS_DEF,
	parameter int FRAC_BITS       = lmc_pkg::FRAC_BITS_DEF,
	localparam int ACC_BITS       = lmc_pkg::acc_bits(DATA_BITS)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [NODE_INDEX_BITS-1:0] node_index,
	input  logic [4:0]                 direction,
	input  logic [DATA_BITS-1:0]       f_value,
	input  logic [DATA_BITS-1:0]       g_value,
	input  logic [7:0]                 node_mask,
	input  logic                       last_direction,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [NODE_INDEX_BITS-1:0] result_node,
	input  logic                       moments_valid,
	input  logic [ACC_BITS-1:0]        density,
	input  logic [DATA_BITS-1:0]       velocity_x,
	input  logic [DATA_BITS-1:0]       velocity_y,
	input  logic [DATA_BITS-1:0]       velocity_z,
	input  logic [ACC_BITS-1:0]        order_parameter,
	input  logic                       divide_fault,
	output int                         error_count,
	output int                         pending
);

	import lmc_pkg::*;

	// lattice velocity set, one bit per direction
	localparam logic [18:0] X_POS = (19'd1 << 1) | (19'd1 << 7) | (19'd1 << 9) |
		(19'd1 << 15) | (19'd1 << 17);
	localparam logic [18:0] X_NEG = (19'd1 << 2) | (19'd1 << 8) | (19'd1 << 10) |
		(19'd1 << 16) | (19'd1 << 18);
	localparam logic [18:0] Y_POS = (19'd1 << 3) | (19'd1 << 7) | (19'd1 << 8) |
		(19'd1 << 11) | (19'd1 << 13);
	localparam logic [18:0] Y_NEG = (19'd1 << 4) | (19'd1 << 9) | (19'd1 << 10) |
		(19'd1 << 12) | (19'd1 << 14);
	localparam logic [18:0] Z_POS = (19'd1 << 5) | (19'd1 << 11) | (19'd1 << 12) |
		(19'd1 << 15) | (19'd1 << 16);
	localparam logic [18:0] Z_NEG = (19'd1 << 6) | (19'd1 << 13) | (19'd1 << 14) |
		(19'd1 << 17) | (19'd1 << 18);

	typedef struct {
		logic [NODE_INDEX_BITS-1:0] node;
		logic                       valid;
		logic [ACC_BITS-1:0]        rho;
		logic [DATA_BITS-1:0]       ux;
		logic [DATA_BITS-1:0]       uy;
		logic [DATA_BITS-1:0]       uz;
		logic [ACC_BITS-1:0]        phi;
		logic                       fault;
	} node_moments_t;

	node_moments_t moments_due[$];

	logic signed [ACC_BITS-1:0] rho_acc;
	logic signed [ACC_BITS-1:0] mom_x;
	logic signed [ACC_BITS-1:0] mom_y;
	logic signed [ACC_BITS-1:0] mom_z;
	logic signed [ACC_BITS-1:0] phi_acc;
	int                         mismatch_total;

	function automatic sign_t lattice_sign(input logic [18:0] pos, input logic [18:0] neg,
		input logic [4:0] dir);
		if (pos[dir])
			return SGN_POS;
		if (neg[dir])
			return SGN_NEG;
		return SGN_ZERO;
	endfunction

	function automatic logic signed [ACC_BITS-1:0] signed_add(
		input logic signed [ACC_BITS-1:0] acc, input logic signed [DATA_BITS-1:0] val,
		input sign_t sgn);
		case (sgn)
			SGN_POS: return acc + val;
			SGN_NEG: return acc - val;
			default: return acc;
		endcase
	endfunction

	// (num << FRAC_BITS) / den, toward zero, clamped to the data range
	function automatic logic [DATA_BITS-1:0] velocity_ratio(
		input logic signed [ACC_BITS-1:0] num, input logic signed [ACC_BITS-1:0] den);
		logic signed [63:0] ns;
		logic signed [63:0] ds;
		logic [63:0] n;
		logic [63:0] d;
		logic [63:0] q;
		logic [63:0] r;
		logic [63:0] cap;
		logic [63:0] qbit;
		logic        neg;
		int          i;
		ns = num;
		ds = den;
		neg = ns[63] ^ ds[63];
		n = ns[63] ? 64'd0 - ns : ns;
		d = ds[63] ? 64'd0 - ds : ds;
		cap = 64'd1 << (DATA_BITS - 1);
		q = n / d;
		r = n % d;
		if (q > cap)
			q = cap;
		for (i = 0; i < FRAC_BITS; i++) begin
			qbit = 64'd0;
			r = r << 1;
			if (r >= d) begin
				r = r - d;
				qbit = 64'd1;
			end
			if (q > cap / 2)
				q = cap;
			else
				q = (q << 1) | qbit;
			if (q > cap)
				q = cap;
		end
		if (!neg) begin
			if (q > cap - 1)
				q = cap - 1;
			return q[DATA_BITS-1:0];
		end
		q = 64'd0 - q;
		return q[DATA_BITS-1:0];
	endfunction

	task automatic compare_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			mismatch_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		node_moments_t want;
		node_moments_t closed;
		if (!arst_n) begin
			rho_acc = '0;
			mom_x = '0;
			mom_y = '0;
			mom_z = '0;
			phi_acc = '0;
			mismatch_total = 0;
			moments_due.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (moments_due.size() == 0) begin
					$error("result word for node %h with no node closed", result_node);
					mismatch_total++;
				end else begin
					want = moments_due.pop_front();
					compare_field("result_node", want.node, result_node);
					compare_field("moments_valid", want.valid, moments_valid);
					compare_field("density", want.rho, density);
					compare_field("velocity_x", want.ux, velocity_x);
					compare_field("velocity_y", want.uy, velocity_y);
					compare_field("velocity_z", want.uz, velocity_z);
					compare_field("order_parameter", want.phi, order_parameter);
					compare_field("divide_fault", want.fault, divide_fault);
				end
			end
			if (in_valid && !in_stall) begin
				if (direction < NUM_DIRS) begin
					rho_acc = signed_add(rho_acc, $signed(f_value), SGN_POS);
					mom_x = signed_add(mom_x, $signed(f_value),
						lattice_sign(X_POS, X_NEG, direction));
					mom_y = signed_add(mom_y, $signed(f_value),
						lattice_sign(Y_POS, Y_NEG, direction));
					mom_z = signed_add(mom_z, $signed(f_value),
						lattice_sign(Z_POS, Z_NEG, direction));
					phi_acc = signed_add(phi_acc, $signed(g_value), SGN_POS);
				end
				if (last_direction) begin
					closed.node = node_index;
					closed.valid = 1'b0;
					closed.rho = '0;
					closed.ux = '0;
					closed.uy = '0;
					closed.uz = '0;
					closed.phi = '0;
					closed.fault = 1'b0;
					if (node_mask != SKIP_MASK) begin
						closed.valid = 1'b1;
						closed.rho = rho_acc;
						closed.phi = phi_acc;
						if (rho_acc == '0) begin
							closed.fault = 1'b1;
						end else begin
							closed.ux = velocity_ratio(mom_x, rho_acc);
							closed.uy = velocity_ratio(mom_y, rho_acc);
							closed.uz = velocity_ratio(mom_z, rho_acc);
						end
					end
					moments_due.push_back(closed);
					rho_acc = '0;
					mom_x = '0;
					mom_y = '0;
					mom_z = '0;
					phi_acc = '0;
				end
			end
		end
		pending <= moments_due.size();
		error_count <= mismatch_total;
	end

endmodule

>>> test/tb_lbm_d3q19_moment_compute.sv
// ----------------------------------------------------------------------------
// tb_lbm_d3q19_moment_compute
// Drives direction words into the D3Q19 moment unit: a directed set of nodes
// for saturation, zero density, masked nodes and unused directions, then
// random nodes (full, short, long and wrapping, noisy) with random idling on
// the input and random stalls on the output. The checker does the compare.
// ----------------------------------------------------------------------------
module tb_lbm_d3q19_moment_compute;

	import lmc_pkg::*;

	localparam int NB = NODE_INDEX_BITS_DEF;
	localparam int DW = DATA_BITS_DEF;
	localparam int AW = acc_bits(DW);
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 80;
	localparam logic [DW-1:0] ONE = 32'h1000_0000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [NB-1:0]        node_index = '0;
	logic [4:0]           direction = '0;
	logic signed [DW-1:0] f_value = '0;
	logic signed [DW-1:0] g_value = '0;
	logic [7:0]           node_mask = '0;
	logic                 last_direction = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [NB-1:0]        result_node;
	logic                 moments_valid;
	logic signed [AW-1:0] density;
	logic signed [DW-1:0] velocity_x;
	logic signed [DW-1:0] velocity_y;
	logic signed [DW-1:0] velocity_z;
	logic signed [AW-1:0] order_parameter;
	logic                 divide_fault;

	int error_count;
	int pending;
	int cycle_count = 0;
	bit in_quiet = 1'b0;
	bit out_quiet = 1'b0;

	lbm_d3q19_moment_compute u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.node_index     (node_index),
		.direction      (direction),
		.f_value        (f_value),
		.g_value        (g_value),
		.node_mask      (node_mask),
		.last_direction (last_direction),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_node    (result_node),
		.moments_valid  (moments_valid),
		.density        (density),
		.velocity_x     (velocity_x),
		.velocity_y     (velocity_y),
		.velocity_z     (velocity_z),
		.order_parameter(order_parameter),
		.divide_fault   (divide_fault)
	);

	lbm_moment_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.node_index     (node_index),
		.direction      (direction),
		.f_value        (f_value),
		.g_value        (g_value),
		.node_mask      (node_mask),
		.last_direction (last_direction),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_node    (result_node),
		.moments_valid  (moments_valid),
		.density        (density),
		.velocity_x     (velocity_x),
		.velocity_y     (velocity_y),
		.velocity_z     (velocity_z),
		.order_parameter(order_parameter),
		.divide_fault   (divide_fault),
		.error_count    (error_count),
		.pending        (pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_lbm_d3q19_moment_compute: done, errors");
			$finish;
		end
	end

	// mostly near-equilibrium populations, with full-range and extreme values
	function automatic logic [DW-1:0] lattice_value();
		int v;
		case ($urandom_range(0, 7))
			0: return $urandom();
			1: begin
				case ($urandom_range(0, 4))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					3: return 32'h0000_0001;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: begin
				v = 14128181 + int'($urandom_range(0, 4000000)) - 2000000;
				return v;
			end
		endcase
	endfunction

	task automatic send_word(input logic [NB-1:0] nd, input logic [4:0] dr,
		input logic [DW-1:0] fv, input logic [DW-1:0] gv, input logic [7:0] mk,
		input logic lst);
		int gap;
		gap = in_quiet ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		node_index <= nd;
		direction <= dr;
		f_value <= fv;
		g_value <= gv;
		node_mask <= mk;
		last_direction <= lst;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// result side: stall a drawn number of cycles once a word is offered
	initial begin
		int gap;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			gap = out_quiet ? 0 : $urandom_range(0, 3);
			if (gap > 0) begin
				out_stall <= 1'b1;
				@(posedge clk);
				while (!out_valid)
					@(posedge clk);
				repeat (gap - 1) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			if ($urandom_range(0, 7) == 0)
				out_quiet = !out_quiet;
		end
	end

	initial begin
		int            rand_words;
		int            kind;
		int            len;
		int            i;
		int            j;
		logic [4:0]    order [19];
		logic [4:0]    swap_dir;
		logic [NB-1:0] nd;
		logic [7:0]    last_mask;
		logic [4:0]    dr;
		logic [DW-1:0] fv;
		logic [DW-1:0] gv;
		logic          lst;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// extremes of the fields on single-word nodes
		send_word(20'hFFFFF, 5'd0, 32'h7FFF_FFFF, 32'h8000_0000, 8'hFF, 1'b1);
		send_word(20'h00000, 5'd1, 32'h8000_0000, 32'h7FFF_FFFF, 8'h00, 1'b1);
		// zero density, then zero density with nonzero momentum
		send_word(20'h00001, 5'd0, 32'h0, 32'h0, 8'h00, 1'b1);
		send_word(20'h00002, 5'd1, 32'd5, 32'd3, 8'h11, 1'b0);
		send_word(20'h00002, 5'd2, 32'hFFFF_FFFB, 32'd1, 8'h11, 1'b1);
		// density of one LSB against huge momentum: clamp high, then low
		send_word(20'h00003, 5'd1, 32'h7FFF_FFFF, 32'h0, 8'h01, 1'b0);
		send_word(20'h00003, 5'd2, 32'h8000_0002, 32'h0, 8'h01, 1'b1);
		send_word(20'h00004, 5'd3, 32'h8000_0002, 32'h0, 8'h02, 1'b0);
		send_word(20'h00004, 5'd4, 32'h7FFF_FFFF, 32'h0, 8'h02, 1'b1);
		// skip mask on the closing word
		send_word(20'h00005, 5'd7, ONE, ONE, 8'h00, 1'b0);
		send_word(20'h00005, 5'd18, ONE, ONE, SKIP_MASK, 1'b1);
		// only the closing word's mask and index count
		send_word(20'h00006, 5'd11, ONE, ONE, SKIP_MASK, 1'b0);
		send_word(20'hABCDE, 5'd14, ONE, 32'h0800_0000, 8'd27, 1'b1);
		// directions past the set add nothing but still close the node
		send_word(20'h00007, 5'd0, ONE, 32'h0800_0000, 8'h00, 1'b0);
		send_word(20'h00007, 5'd19, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'h00, 1'b0);
		send_word(20'h00007, 5'd31, 32'h8000_0000, 32'h8000_0000, 8'd29, 1'b1);

		rand_words = 0;
		while (rand_words < 800) begin
			kind = $urandom_range(0, 9);
			nd = NB'($urandom());
			if (kind == 9 || $urandom_range(0, 5) == 0)
				last_mask = SKIP_MASK;
			else
				last_mask = 8'($urandom_range(0, 255));
			case (kind)
				6: len = $urandom_range(1, 6);
				7: len = $urandom_range(20, 40);
				8: len = $urandom_range(1, 8);
				default: len = 19;
			endcase
			for (i = 0; i < 19; i++)
				order[i] = 5'(i);
			for (i = 18; i > 0; i--) begin
				j = $urandom_range(0, i);
				swap_dir = order[i];
				order[i] = order[j];
				order[j] = swap_dir;
			end
			if ($urandom_range(0, 5) == 0)
				in_quiet = !in_quiet;
			for (i = 0; i < len; i++) begin
				case (kind)
					6, 7: dr = 5'($urandom_range(0, 18));
					8: dr = 5'($urandom_range(0, 31));
					default: dr = order[i];
				endcase
				if (kind == 7) begin
					// long runs of extremes wrap the sums
					fv = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
					gv = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
					if ($urandom_range(0, 3) == 0)
						fv = lattice_value();
				end else begin
					fv = lattice_value();
					gv = lattice_value();
				end
				lst = (i == len - 1);
				send_word((lst || $urandom_range(0, 7) != 0) ? nd : NB'($urandom()), dr, fv,
					gv, lst ? last_mask : 8'($urandom_range(0, 255)), lst);
				rand_words++;
			end
		end
		in_valid <= 1'b0;

		// let the checker count the node closed by the final word
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb_lbm_d3q19_moment_compute: done, clean");
		else
			$display("tb_lbm_d3q19_moment_compute: done, errors");
		$finish;
	end

endmodule
